// ----- rtl/core/assert_macros.svh -----
// assertion macros for the light pen and joystick frame parser
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising edge, off while reset is low
`define LPJ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// same check, also evaluated while reset is held
`define LPJ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/core/lpj_pkg.sv -----
// types and constants of the light pen and joystick frame parser
// no dependencies
`timescale 1ns / 1ps

package lpj_pkg;

    typedef enum logic [1:0] {
        POS_X    = 2'd0,
        POS_Y    = 2'd1,
        POS_PAD1 = 2'd2,
        POS_PAD2 = 2'd3
    } t_frame_pos;

    localparam logic [7:0]  TOP_MARK    = 8'hE0;
    localparam logic [7:0]  X_OFFSET    = 8'd94;
    localparam logic [7:0]  Y_OFFSET    = 8'd150;
    localparam logic [7:0]  Y_LOW_LIMIT = 8'd32;
    localparam logic [7:0]  Y_FILL      = 8'd255;
    localparam logic [7:0]  CENTER      = 8'd128;
    localparam logic [7:0]  BYTE_MAX    = 8'd255;
    // floor(m / 25) == (m * 5243) >> 17 for every m below 43690
    localparam logic [12:0] RECIP_25    = 13'd5243;
    localparam int          RECIP_SHIFT = 17;

    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 32;

endpackage

// ----- rtl/core/light_pen_joystick_frame_parser.sv -----
// light pen and joystick frame parser, top level
// depends on lpj_pkg and assert_macros.svh
//
// usage:
//   slave stream (i_s_*) takes one received serial byte per request in tdata.
//   bytes form a four-byte frame: pen x, pen y, joystick one, joystick two.
//   master stream (o_m_*) returns one result per byte with the latest held
//   pen x/y, both pressed-flag sets and the position expected next.
//   a joystick position byte without its top three bits set resyncs the
//   frame and is taken as pen x.
// result path: an accepted byte is registered in the input register, then
//   processed into the hold registers that form the result register.
// throughput: one byte per cycle unless results stall; the single shared
//   reciprocal multiplier and clamp sit between input and hold registers.
// stall: while the result waits, one more byte is held in the input
//   register; tready drops only when both registers are full.
// reset: synchronous, active low; position returns to pen x, holds clear
//   to zero and both registers empty.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module light_pen_joystick_frame_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata    // [7:0] pen_x, [15:8] pen_y, [20:16] pad1_pressed,
                                     // [25:21] pad2_pressed, [27:26] frame_position, rest 0
);

    logic                  r_in_valid;
    logic [7:0]            r_in_byte;
    logic                  r_out_valid;
    lpj_pkg::t_frame_pos   r_pos, n_pos, eff_pos;
    logic [7:0]            r_x, n_x;
    logic [7:0]            r_y, n_y;
    logic [4:0]            r_pad1, n_pad1;
    logic [4:0]            r_pad2, n_pad2;

    logic                  out_free;
    logic                  r_move;
    logic                  in_take;

    logic [7:0]            y_byte;
    logic                  x_neg, y_neg, op_neg;
    logic [7:0]            x_mag, y_mag, op_mag;
    logic [12:0]           mul_a;
    logic [25:0]           prod;
    logic [8:0]            quot;
    logic [9:0]            x_step;
    logic [10:0]           up_sum;

    assign out_free   = !r_out_valid || i_m_tready;
    assign r_move     = r_in_valid && out_free;
    assign o_s_tready = !r_in_valid || out_free;
    assign in_take    = i_s_tvalid && o_s_tready;

    // resync on a joystick slot byte without the top mark
    always_comb begin
        eff_pos = r_pos;
        if ((r_pos == lpj_pkg::POS_PAD1 || r_pos == lpj_pkg::POS_PAD2) &&
            ((r_in_byte & lpj_pkg::TOP_MARK) != lpj_pkg::TOP_MARK)) begin
            eff_pos = lpj_pkg::POS_X;
        end
    end

    // one shared scaler: |d| * 128 / 100 == (|d| * 32) / 25
    always_comb begin
        y_byte = (r_in_byte < lpj_pkg::Y_LOW_LIMIT) ? lpj_pkg::Y_FILL : r_in_byte;
        x_neg  = r_in_byte < lpj_pkg::X_OFFSET;
        x_mag  = x_neg ? (lpj_pkg::X_OFFSET - r_in_byte) : (r_in_byte - lpj_pkg::X_OFFSET);
        y_neg  = y_byte < lpj_pkg::Y_OFFSET;
        y_mag  = y_neg ? (lpj_pkg::Y_OFFSET - y_byte) : (y_byte - lpj_pkg::Y_OFFSET);
        op_neg = (eff_pos == lpj_pkg::POS_X) ? x_neg : y_neg;
        op_mag = (eff_pos == lpj_pkg::POS_X) ? x_mag : y_mag;
        mul_a  = {op_mag, 5'b0};
        prod   = 26'(mul_a) * 26'(lpj_pkg::RECIP_25);
        quot   = prod[25:lpj_pkg::RECIP_SHIFT];
    end

    always_comb begin
        n_pos  = r_pos;
        n_x    = r_x;
        n_y    = r_y;
        n_pad1 = r_pad1;
        n_pad2 = r_pad2;
        x_step = {quot, 1'b0};
        up_sum = 11'd0;
        if (r_move) begin
            unique case (eff_pos)
                lpj_pkg::POS_X: begin
                    up_sum = 11'(lpj_pkg::CENTER) + 11'(x_step);
                    if (op_neg) begin
                        n_x = (x_step >= 10'(lpj_pkg::CENTER)) ? 8'd0
                            : 8'(10'(lpj_pkg::CENTER) - x_step);
                    end else begin
                        n_x = (up_sum > 11'(lpj_pkg::BYTE_MAX)) ? lpj_pkg::BYTE_MAX
                            : up_sum[7:0];
                    end
                    n_pos = lpj_pkg::POS_Y;
                end
                lpj_pkg::POS_Y: begin
                    up_sum = 11'(lpj_pkg::CENTER) + 11'(quot);
                    if (op_neg) begin
                        n_y = (quot >= 9'(lpj_pkg::CENTER)) ? 8'd0
                            : 8'(9'(lpj_pkg::CENTER) - quot);
                    end else begin
                        n_y = (up_sum > 11'(lpj_pkg::BYTE_MAX)) ? lpj_pkg::BYTE_MAX
                            : up_sum[7:0];
                    end
                    n_pos = lpj_pkg::POS_PAD1;
                end
                lpj_pkg::POS_PAD1: begin
                    n_pad1 = ~r_in_byte[4:0];
                    n_pos  = lpj_pkg::POS_PAD2;
                end
                lpj_pkg::POS_PAD2: begin
                    n_pad2 = ~r_in_byte[4:0];
                    n_pos  = lpj_pkg::POS_X;
                end
                default: begin
                    n_pos = lpj_pkg::POS_X;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pos       <= lpj_pkg::POS_X;
            r_x         <= 8'd0;
            r_y         <= 8'd0;
            r_pad1      <= 5'd0;
            r_pad2      <= 5'd0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (r_move) begin
                r_in_valid <= 1'b0;
            end
            if (r_move) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            r_pos  <= n_pos;
            r_x    <= n_x;
            r_y    <= n_y;
            r_pad1 <= n_pad1;
            r_pad2 <= n_pad2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_s_tdata;
        end
    end

    // the hold registers are the result register
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'd0, r_pos, r_pad2, r_pad1, r_y, r_x};

    `LPJ_ASSERT(a_resync_to_y, i_clk, i_rst_n,
        r_move && (r_pos == lpj_pkg::POS_PAD1 || r_pos == lpj_pkg::POS_PAD2) &&
        (r_in_byte[7:5] != 3'b111) |=> r_pos == lpj_pkg::POS_Y,
        "resync byte not taken as pen x")
    `LPJ_ASSERT(a_hold_stable, i_clk, i_rst_n,
        !r_move |=> $stable(r_pos) && $stable(r_x) && $stable(r_y) &&
        $stable(r_pad1) && $stable(r_pad2),
        "result state changed without a request")
    `LPJ_ASSERT(a_move_gives_result, i_clk, i_rst_n,
        r_move |=> r_out_valid,
        "processed byte gave no result")
    `LPJ_ASSERT(a_input_kept, i_clk, i_rst_n,
        r_in_valid && !r_move |=> r_in_valid && $stable(r_in_byte),
        "pending input byte lost")

endmodule
